[rtl/core/asa_pkg.sv]
// Shared constants, codes and types of the animation step ALU.
`default_nettype none
package asa_pkg;

    localparam int WORD_BITS     = 32;
    localparam int FRACTION_BITS = 16;
    localparam int TICK_BITS     = WORD_BITS - 1;
    localparam int OP_BITS       = 4;
    localparam int ST_BITS       = 2;

    // magnitude of a difference of two words
    localparam int DIFF_BITS = WORD_BITS + 1;
    // first product and its fixed-point rescale
    localparam int PROD_BITS = 2 * WORD_BITS;
    localparam int P1_BITS   = PROD_BITS - FRACTION_BITS;
    localparam int SPLIT     = P1_BITS / 2;
    localparam int PP_BITS   = (P1_BITS - SPLIT) + DIFF_BITS;
    localparam int FULL_BITS = P1_BITS + DIFF_BITS;
    localparam int P2_BITS   = FULL_BITS - FRACTION_BITS;
    // signed intermediate and its magnitude
    localparam int VAL_BITS  = P2_BITS + 2;
    localparam int MAG_BITS  = VAL_BITS - 1;

    // divider: dividend width rounded up to whole stages
    localparam int DIV_STEP   = 4;
    localparam int DVD_MIN    = DIFF_BITS + FRACTION_BITS;
    localparam int DIV_STAGES = (DVD_MIN + DIV_STEP - 1) / DIV_STEP;
    localparam int DVD_BITS   = DIV_STAGES * DIV_STEP;

    // stream widths
    localparam int IN_RAW_BITS   = 3 * WORD_BITS + TICK_BITS;
    localparam int IN_DATA_BITS  = ((IN_RAW_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_BITS = 2 * WORD_BITS;

    typedef logic [OP_BITS-1:0] t_op;
    typedef logic [1:0]         t_kind;

    localparam t_op OP_ADD   = 4'd0;
    localparam t_op OP_SUB   = 4'd1;
    localparam t_op OP_MUL   = 4'd2;
    localparam t_op OP_DIV   = 4'd3;
    localparam t_op OP_PROP  = 4'd4;
    localparam t_op OP_LIN   = 4'd5;
    localparam t_op OP_INTEG = 4'd6;
    localparam t_op OP_DERIV = 4'd7;
    localparam t_op OP_MOD   = 4'd8;
    localparam t_op OP_TIMER = 4'd9;

    // how the final stage forms the output
    localparam t_kind K_PACK = 2'd0;  // saturate carried sign/magnitude
    localparam t_kind K_RAW  = 2'd1;  // pass a raw word
    localparam t_kind K_DIV  = 2'd2;  // saturate quotient
    localparam t_kind K_MOD  = 2'd3;  // remainder

    localparam logic [ST_BITS-1:0] ST_OK   = 2'd0;
    localparam logic [ST_BITS-1:0] ST_KEPT = 2'd1;
    localparam logic [ST_BITS-1:0] ST_SAT  = 2'd2;

    typedef struct packed {
        t_kind                kind;
        logic                 res_neg;
        logic                 kept;
        logic [WORD_BITS-1:0] raw;
        logic [WORD_BITS-1:0] mem;
        logic [MAG_BITS-1:0]  mag;
    } t_side;

    typedef struct packed {
        logic [DVD_BITS-1:0]  dvd;
        logic [WORD_BITS-1:0] dvs;
    } t_div;

    typedef struct packed {
        logic [WORD_BITS-1:0] out_new;
        logic [WORD_BITS-1:0] mem;
        logic [ST_BITS-1:0]   status;
    } t_result;

endpackage
`default_nettype wire

[rtl/core/asa_front.sv]
// Operand decode, split multiplier and divider set-up stages.
`default_nettype none
module asa_front import asa_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_en,
    input  wire logic                 i_valid,
    input  wire t_op                  i_op,
    input  wire logic [WORD_BITS-1:0] i_a,
    input  wire logic [WORD_BITS-1:0] i_b,
    input  wire logic [WORD_BITS-1:0] i_o,
    input  wire logic [TICK_BITS-1:0] i_t,
    output logic                      o_valid,
    output t_side                     o_side,
    output t_div                      o_div
);

    typedef struct packed {
        t_op                  op;
        logic [WORD_BITS-1:0] a;
        logic [WORD_BITS-1:0] b;
        logic [WORD_BITS-1:0] o;
        logic [TICK_BITS-1:0] t;
        logic [WORD_BITS-1:0] bmag;
        logic                 dneg;
        logic [DIFF_BITS-1:0] dmag;
        logic                 pneg;
    } t_carry;

    logic [5:0] r_vld;

    // stage A
    t_carry               n_ca, r_ca;
    logic [WORD_BITS-1:0] n_m1x, n_m1y, r_m1x, r_m1y;
    logic [DIFF_BITS-1:0] n_m2y, r_m2y_a;
    logic [WORD_BITS-1:0] a_mag;
    logic [DIFF_BITS-1:0] diff;
    // stage B
    t_carry               r_cb;
    logic [PROD_BITS-1:0] r_prod;
    logic [DIFF_BITS-1:0] r_m2y_b;
    // stage C
    t_carry               r_cc;
    logic [P1_BITS-1:0]   p1_c, r_p1_c;
    logic [PP_BITS-1:0]   r_pl, r_ph;
    // stage D
    t_carry               r_cd;
    logic [P1_BITS-1:0]   r_p1_d;
    logic [FULL_BITS-1:0] full;
    logic [P2_BITS-1:0]   r_p2;
    // stage E
    logic signed [VAL_BITS-1:0] sa, sb, so, p1u, p2u, p1v, p2v, su, sv;
    logic [P2_BITS-1:0]   smag;
    logic                 s_neg, direct;
    t_kind                n_e_kind, r_e_kind;
    logic                 n_e_dneg, r_e_dneg, n_e_kept, r_e_kept;
    logic [WORD_BITS-1:0] n_e_raw, r_e_raw, n_e_mem, r_e_mem, n_e_dvs, r_e_dvs;
    logic signed [VAL_BITS-1:0] n_e_val, r_e_val;
    // stage F
    logic                 vneg;
    logic [MAG_BITS-1:0]  vmag;
    t_side                n_side, r_side;
    t_div                 n_div, r_div;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[4:0], i_valid};
        end
    end

    // ---- stage A: magnitudes and multiplier operands
    always_comb begin
        a_mag = i_a[WORD_BITS-1] ? -i_a : i_a;
        diff  = DIFF_BITS'($signed(i_a)) - DIFF_BITS'($signed(i_o));
        n_ca.op   = i_op;
        n_ca.a    = i_a;
        n_ca.b    = i_b;
        n_ca.o    = i_o;
        n_ca.t    = i_t;
        n_ca.bmag = i_b[WORD_BITS-1] ? -i_b : i_b;
        n_ca.dneg = diff[DIFF_BITS-1];
        n_ca.dmag = diff[DIFF_BITS-1] ? -diff : diff;
        n_ca.pneg = 1'b0;
        n_m1x = '0;
        n_m1y = '0;
        n_m2y = '0;
        case (i_op)
            OP_MUL, OP_INTEG: begin
                n_m1x     = a_mag;
                n_m1y     = n_ca.bmag;
                n_ca.pneg = i_a[WORD_BITS-1] ^ i_b[WORD_BITS-1];
            end
            OP_PROP, OP_LIN: begin
                n_m1x     = WORD_BITS'(i_t);
                n_m1y     = n_ca.bmag;
                n_ca.pneg = i_b[WORD_BITS-1];
            end
            OP_TIMER: begin
                n_m1x     = a_mag;
                n_m1y     = WORD_BITS'(i_t);
                n_ca.pneg = i_a[WORD_BITS-1];
            end
            default: ;
        endcase
        if (i_op == OP_INTEG) begin
            n_m2y = DIFF_BITS'(i_t);
        end else if (i_op == OP_PROP) begin
            n_m2y = n_ca.dmag;
        end
    end

    // ---- stage B: first product; stage C: rescale and split second product
    assign p1_c = r_prod[PROD_BITS-1:FRACTION_BITS];

    // ---- stage D: recombine second product
    assign full = (FULL_BITS'(r_ph) << SPLIT) + FULL_BITS'(r_pl);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ca    <= n_ca;
            r_m1x   <= n_m1x;
            r_m1y   <= n_m1y;
            r_m2y_a <= n_m2y;

            r_cb    <= r_ca;
            r_prod  <= PROD_BITS'(r_m1x) * PROD_BITS'(r_m1y);
            r_m2y_b <= r_m2y_a;

            r_cc    <= r_cb;
            r_p1_c  <= p1_c;
            r_pl    <= PP_BITS'(p1_c[SPLIT-1:0]) * PP_BITS'(r_m2y_b);
            r_ph    <= PP_BITS'(p1_c[P1_BITS-1:SPLIT]) * PP_BITS'(r_m2y_b);

            r_cd    <= r_cc;
            r_p1_d  <= r_p1_c;
            r_p2    <= full[FULL_BITS-1:FRACTION_BITS];
        end
    end

    // ---- stage E: signed intermediate per opcode
    always_comb begin
        sa  = VAL_BITS'($signed(r_cd.a));
        sb  = VAL_BITS'($signed(r_cd.b));
        so  = VAL_BITS'($signed(r_cd.o));
        p1u = VAL_BITS'(r_p1_d);
        p2u = VAL_BITS'(r_p2);
        p1v = r_cd.pneg ? -p1u : p1u;
        p2v = r_cd.pneg ? -p2u : p2u;
        // approach step; a zero step counts as positive
        smag   = (r_cd.op == OP_PROP) ? r_p2 : P2_BITS'(r_p1_d);
        s_neg  = r_cd.pneg & (|smag);
        direct = !s_neg && (smag > P2_BITS'(r_cd.dmag));
        su     = VAL_BITS'(smag);
        sv     = r_cd.dneg ? -su : su;

        n_e_kind = K_RAW;
        n_e_dneg = 1'b0;
        n_e_kept = 1'b0;
        n_e_raw  = r_cd.o;
        n_e_mem  = r_cd.b;
        n_e_dvs  = r_cd.bmag;
        n_e_val  = '0;
        case (r_cd.op)
            OP_ADD: begin
                n_e_kind = K_PACK;
                n_e_val  = sa + sb;
            end
            OP_SUB: begin
                n_e_kind = K_PACK;
                n_e_val  = sa - sb;
            end
            OP_MUL: begin
                n_e_kind = K_PACK;
                n_e_val  = p1v;
            end
            OP_DIV: begin
                if (r_cd.bmag == '0) begin
                    n_e_kept = 1'b1;
                end else begin
                    n_e_kind = K_DIV;
                    n_e_val  = sa;
                    n_e_dneg = r_cd.b[WORD_BITS-1];
                end
            end
            OP_PROP, OP_LIN: begin
                if (direct) begin
                    n_e_raw = r_cd.a;
                end else begin
                    n_e_kind = K_PACK;
                    n_e_val  = so + sv;
                end
            end
            OP_INTEG: begin
                n_e_kind = K_PACK;
                n_e_val  = so + p2v;
            end
            OP_DERIV: begin
                n_e_mem = r_cd.a;
                if (r_cd.t == '0) begin
                    n_e_kept = 1'b1;
                end else begin
                    n_e_kind = K_DIV;
                    n_e_val  = sa - sb;
                    n_e_dvs  = WORD_BITS'(r_cd.t);
                end
            end
            OP_MOD, OP_TIMER: begin
                if (r_cd.bmag == '0) begin
                    n_e_kept = 1'b1;
                end else begin
                    n_e_kind = K_MOD;
                    n_e_val  = (r_cd.op == OP_MOD) ? sa : so + p1v;
                end
            end
            default: ;
        endcase
    end

    // ---- stage F: sign/magnitude and divider operands
    always_comb begin
        vneg = r_e_val[VAL_BITS-1];
        vmag = MAG_BITS'(vneg ? -r_e_val : r_e_val);
        n_side.kind    = r_e_kind;
        n_side.res_neg = (r_e_kind == K_DIV) ? (vneg ^ r_e_dneg) : vneg;
        n_side.kept    = r_e_kept;
        n_side.raw     = r_e_raw;
        n_side.mem     = r_e_mem;
        n_side.mag     = vmag;
        n_div.dvs      = r_e_dvs;
        if (r_e_kind == K_DIV) begin
            n_div.dvd = DVD_BITS'({vmag[DIFF_BITS-1:0], {FRACTION_BITS{1'b0}}});
        end else begin
            n_div.dvd = DVD_BITS'(vmag);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_e_kind <= n_e_kind;
            r_e_dneg <= n_e_dneg;
            r_e_kept <= n_e_kept;
            r_e_raw  <= n_e_raw;
            r_e_mem  <= n_e_mem;
            r_e_dvs  <= n_e_dvs;
            r_e_val  <= n_e_val;
            r_side   <= n_side;
            r_div    <= n_div;
        end
    end

    assign o_valid = r_vld[5];
    assign o_side  = r_side;
    assign o_div   = r_div;

endmodule
`default_nettype wire

[rtl/core/asa_div.sv]
// Pipelined restoring divider, a few quotient bits per stage.
`default_nettype none
module asa_div import asa_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_en,
    input  wire logic                 i_valid,
    input  wire t_div                 i_div,
    input  wire t_side                i_side,
    output logic                      o_valid,
    output logic [DVD_BITS-1:0]       o_quo,
    output logic [WORD_BITS-1:0]      o_rem,
    output t_side                     o_side
);

    logic [DIV_STAGES-1:0] r_vld;
    logic [WORD_BITS-1:0]  r_rem [DIV_STAGES];
    logic [DVD_BITS-1:0]   r_dq  [DIV_STAGES];
    logic [WORD_BITS-1:0]  r_dvs [DIV_STAGES];
    t_side                 r_sd  [DIV_STAGES];
    logic [WORD_BITS-1:0]  n_rem [DIV_STAGES];
    logic [DVD_BITS-1:0]   n_dq  [DIV_STAGES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[DIV_STAGES-2:0], i_valid};
        end
    end

    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
        logic [WORD_BITS-1:0] in_rem;
        logic [DVD_BITS-1:0]  in_dq;
        logic [WORD_BITS-1:0] in_dvs;
        t_side                in_sd;

        if (g == 0) begin : g_first
            assign in_rem = '0;
            assign in_dq  = i_div.dvd;
            assign in_dvs = i_div.dvs;
            assign in_sd  = i_side;
        end else begin : g_next
            assign in_rem = r_rem[g-1];
            assign in_dq  = r_dq[g-1];
            assign in_dvs = r_dvs[g-1];
            assign in_sd  = r_sd[g-1];
        end

        // dividend bits leave at the top, quotient bits enter at the bottom
        always_comb begin
            logic [WORD_BITS:0]   r2;
            logic [WORD_BITS-1:0] rem;
            logic [DVD_BITS-1:0]  dq;
            rem = in_rem;
            dq  = in_dq;
            r2  = '0;
            for (int k = 0; k < DIV_STEP; k++) begin
                r2 = {rem, dq[DVD_BITS-1]};
                dq = {dq[DVD_BITS-2:0], 1'b0};
                if (r2 >= {1'b0, in_dvs}) begin
                    r2    = r2 - {1'b0, in_dvs};
                    dq[0] = 1'b1;
                end
                rem = r2[WORD_BITS-1:0];
            end
            n_rem[g] = rem;
            n_dq[g]  = dq;
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g] <= n_rem[g];
                r_dq[g]  <= n_dq[g];
                r_dvs[g] <= in_dvs;
                r_sd[g]  <= in_sd;
            end
        end
    end

    assign o_valid = r_vld[DIV_STAGES-1];
    assign o_quo   = r_dq[DIV_STAGES-1];
    assign o_rem   = r_rem[DIV_STAGES-1];
    assign o_side  = r_sd[DIV_STAGES-1];

endmodule
`default_nettype wire

[rtl/core/asa_fin.sv]
// Result selection and saturation to the word range.
`default_nettype none
module asa_fin import asa_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_en,
    input  wire logic                 i_valid,
    input  wire logic [DVD_BITS-1:0]  i_quo,
    input  wire logic [WORD_BITS-1:0] i_rem,
    input  wire t_side                i_side,
    output logic                      o_valid,
    output t_result                   o_res
);

    localparam logic [MAG_BITS-1:0] LIM_POS =
        {{(MAG_BITS-WORD_BITS+1){1'b0}}, {(WORD_BITS-1){1'b1}}};
    localparam logic [MAG_BITS-1:0] LIM_NEG = LIM_POS + MAG_BITS'(1);
    localparam logic [WORD_BITS-1:0] W_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam logic [WORD_BITS-1:0] W_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

    logic                 r_vld;
    t_result              n_res, r_res;
    logic [MAG_BITS-1:0]  mag;
    logic [WORD_BITS-1:0] low;
    logic                 sat_pos, sat_neg;

    always_comb begin
        case (i_side.kind)
            K_DIV:   mag = MAG_BITS'(i_quo);
            K_MOD:   mag = MAG_BITS'(i_rem);
            default: mag = i_side.mag;
        endcase
        low     = mag[WORD_BITS-1:0];
        sat_pos = !i_side.res_neg && (mag > LIM_POS);
        sat_neg = i_side.res_neg && (mag > LIM_NEG);
        n_res.mem = i_side.mem;
        if (i_side.kind == K_RAW) begin
            n_res.out_new = i_side.raw;
            n_res.status  = i_side.kept ? ST_KEPT : ST_OK;
        end else if (sat_pos) begin
            n_res.out_new = W_MAX;
            n_res.status  = ST_SAT;
        end else if (sat_neg) begin
            n_res.out_new = W_MIN;
            n_res.status  = ST_SAT;
        end else begin
            n_res.out_new = i_side.res_neg ? -low : low;
            n_res.status  = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res <= n_res;
        end
    end

    assign o_valid = r_vld;
    assign o_res   = r_res;

endmodule
`default_nettype wire

[rtl/core/asa_skid.sv]
// Output register with a skid entry; its fill state stalls the pipeline.
`default_nettype none
module asa_skid import asa_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    input  wire t_result i_data,
    output logic         o_ready,
    output logic         o_valid,
    input  wire logic    i_ready,
    output t_result      o_data
);

    logic    r_out_vld, n_out_vld, r_skd_vld, n_skd_vld;
    t_result r_out, n_out, r_skd, n_skd;
    logic    fire, push;

    assign o_ready = ~r_skd_vld;
    assign fire    = r_out_vld & i_ready;
    assign push    = i_valid & ~r_skd_vld;

    always_comb begin
        n_out_vld = r_out_vld;
        n_skd_vld = r_skd_vld;
        n_out     = r_out;
        n_skd     = r_skd;
        if (r_skd_vld) begin
            if (fire) begin
                n_out     = r_skd;
                n_skd_vld = 1'b0;
            end
        end else if (push) begin
            if (!r_out_vld || fire) begin
                n_out     = i_data;
                n_out_vld = 1'b1;
            end else begin
                n_skd     = i_data;
                n_skd_vld = 1'b1;
            end
        end else if (fire) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_skd_vld <= 1'b0;
        end else begin
            r_out_vld <= n_out_vld;
            r_skd_vld <= n_skd_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        r_skd <= n_skd;
    end

    assign o_valid = r_out_vld;
    assign o_data  = r_out;

endmodule
`default_nettype wire

[rtl/core/animation_step_alu.sv]
// Animation step ALU: one Q16.16 step transaction in, one result transaction out.
//
// Slave stream carries a step: opcode in tuser, operands, current output and
// tick length in tdata. Master stream returns the new output value, the new
// memory word (previous a for derivative) in tdata and the status in tuser
// (ok, divisor/tick/modulus zero so output kept, saturated).
// The path holds 21 register stages: six stages of decode, split multiplier
// and divider set-up, thirteen divider stages of four quotient bits each,
// one saturation stage, and the output register. A new transaction is
// taken every cycle while s_axis_tready is high; every opcode runs
// through the same stages so results leave in order.
// When the receiver stalls, the result moves into a one-entry skid buffer
// and s_axis_tready drops the next cycle, freezing the pipeline without
// loss; it rises again once the receiver takes the held result.
// Synchronous active-low reset empties the pipeline and the output stage.
`default_nettype none
module animation_step_alu import asa_pkg::*; (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     s_axis_tvalid,
    output logic                          s_axis_tready,
    // a_value[31:0], b_value[63:32], out_now[95:64], tick_len[126:96], zero pad
    input  wire logic [IN_DATA_BITS-1:0]  s_axis_tdata,
    // op[3:0]
    input  wire logic [OP_BITS-1:0]       s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  wire logic                     m_axis_tready,
    // out_new[31:0], memory_new[63:32]
    output logic [OUT_DATA_BITS-1:0]      m_axis_tdata,
    // status[1:0]
    output logic [ST_BITS-1:0]            m_axis_tuser
);

    logic                 en;
    logic                 f_valid, d_valid, g_valid;
    t_side                f_side, d_side;
    t_div                 f_div;
    logic [DVD_BITS-1:0]  d_quo;
    logic [WORD_BITS-1:0] d_rem;
    t_result              g_res, m_res;

    asa_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (s_axis_tvalid),
        .i_op    (s_axis_tuser),
        .i_a     (s_axis_tdata[WORD_BITS-1:0]),
        .i_b     (s_axis_tdata[2*WORD_BITS-1:WORD_BITS]),
        .i_o     (s_axis_tdata[3*WORD_BITS-1:2*WORD_BITS]),
        .i_t     (s_axis_tdata[IN_RAW_BITS-1:3*WORD_BITS]),
        .o_valid (f_valid),
        .o_side  (f_side),
        .o_div   (f_div)
    );

    asa_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (f_valid),
        .i_div   (f_div),
        .i_side  (f_side),
        .o_valid (d_valid),
        .o_quo   (d_quo),
        .o_rem   (d_rem),
        .o_side  (d_side)
    );

    asa_fin u_fin (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (d_valid),
        .i_quo   (d_quo),
        .i_rem   (d_rem),
        .i_side  (d_side),
        .o_valid (g_valid),
        .o_res   (g_res)
    );

    asa_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (g_valid & en),
        .i_data  (g_res),
        .o_ready (en),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (m_res)
    );

    assign s_axis_tready = en;
    assign m_axis_tdata  = {m_res.mem, m_res.out_new};
    assign m_axis_tuser  = m_res.status;

    // input side only blocks while a result is held at the output
    a_stall_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with no result held");

    // the skid entry fills only from a refused output transaction
    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(s_axis_tready) |-> $past(m_axis_tvalid && !m_axis_tready))
        else $error("skid filled without output stall");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
            (m_axis_tuser == ST_OK || m_axis_tuser == ST_KEPT || m_axis_tuser == ST_SAT))
        else $error("undefined status code");

endmodule
`default_nettype wire
